// File: rtl/rcpn_pkg.sv
package rcpn_pkg;

    // Symbol codes beyond the sixteen nibble values.
    localparam logic [4:0] SYM_REPEAT = 5'd16;
    localparam logic [4:0] SYM_IDLE   = 5'd17;

    // Pulse width is BASE_WIDTH_US + STEP_WIDTH_US * symbol.
    localparam logic [10:0] BASE_WIDTH_US = 11'd1024;
    localparam logic [10:0] STEP_WIDTH_US = 11'd56;

    // Longest hold of one symbol, in frame ticks.
    localparam logic [8:0] MAX_FRAMES = 9'd256;
    localparam logic [8:0] MIN_FRAMES = 9'd1;

    // Configuration reset values.
    localparam logic [8:0] FRAMES_RESET  = 9'd1;
    localparam logic [7:0] CHANNEL_RESET = 8'd255;

    localparam int FIFO_DEPTH_DEF = 16;

    // Command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAMES  = 2'd0,
        CFG_CHANNEL = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic       is_write;
        logic       is_tick;
        logic       is_flush;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic        write_accepted;
        logic        pulse_valid;
        logic [10:0] pulse_len_us;
        logic [4:0]  symbol_sent;
        logic [7:0]  pulse_channel;
        logic        fifo_empty;
        logic [7:0]  head_byte;
    } result_t;

endpackage

// File: rtl/rcpn_front.sv
module rcpn_front
    import rcpn_pkg::*;
(
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    assign item_ready = !q_full;
    assign push       = item_valid && item_ready;

    always_comb
    begin
        push_cmd          = '0;
        push_cmd.data     = data_byte;
        unique case (op)
            OP_WRITE: push_cmd.is_write = 1'b1;
            OP_TICK:  push_cmd.is_tick  = 1'b1;
            OP_FLUSH: push_cmd.is_flush = 1'b1;
            // The unused code travels as a command that changes nothing.
            default:  push_cmd.is_write = 1'b0;
        endcase
    end

endmodule

// File: rtl/rcpn_queue.sv
module rcpn_queue
    import rcpn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/rcpn_back.sv
module rcpn_back
    import rcpn_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       pop,
    input  logic [8:0] frames_per_symbol,
    input  logic [7:0] channel_number,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    localparam int                PTR_W    = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] ptr);
        next_idx = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
    endfunction

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [7:0]       head_reg;
    logic [7:0]       held_reg, held_next;
    logic             low_pending_reg, low_pending_next;
    logic             active_reg, active_next;
    logic [7:0]       frames_reg, frames_next;
    logic [4:0]       cur_sym_reg, cur_sym_next;
    logic [4:0]       prev_sym_reg, prev_sym_next;
    logic             out_valid_reg;
    result_t          out_reg, out_next;

    logic             fire;
    logic             do_write;
    logic             head_bypass;
    logic [PTR_W-1:0] wr_adv;
    logic [8:0]       limit;
    logic [8:0]       count;
    logic [4:0]       pick;
    logic [4:0]       sym;

    assign fire   = q_valid && (!out_valid_reg || result_ready);
    assign pop    = fire;
    assign wr_adv = next_idx(wr_ptr_reg);
    assign count  = {1'b0, frames_reg} + 9'd1;

    always_comb
    begin
        if (frames_per_symbol == '0)
        begin
            limit = MIN_FRAMES;
        end
        else if (frames_per_symbol > MAX_FRAMES)
        begin
            limit = MAX_FRAMES;
        end
        else
        begin
            limit = frames_per_symbol;
        end
    end

    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        held_next        = held_reg;
        low_pending_next = low_pending_reg;
        active_next      = active_reg;
        frames_next      = frames_reg;
        cur_sym_next     = cur_sym_reg;
        prev_sym_next    = prev_sym_reg;
        do_write         = 1'b0;
        pick             = SYM_IDLE;
        sym              = cur_sym_reg;
        out_next         = '0;

        if (fire)
        begin
            if (q_cmd.is_write)
            begin
                if (wr_adv != rd_ptr_reg)
                begin
                    do_write                = 1'b1;
                    wr_ptr_next             = wr_adv;
                    out_next.write_accepted = 1'b1;
                end
            end
            else if (q_cmd.is_tick)
            begin
                if (!active_reg)
                begin
                    active_next = 1'b1;
                    if (!low_pending_reg)
                    begin
                        if (rd_ptr_reg != wr_ptr_reg)
                        begin
                            held_next        = head_reg;
                            rd_ptr_next      = next_idx(rd_ptr_reg);
                            pick             = {1'b0, head_reg[7:4]};
                            low_pending_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pick             = {1'b0, held_reg[3:0]};
                        low_pending_next = 1'b0;
                    end
                    if (pick == prev_sym_reg)
                    begin
                        pick = SYM_REPEAT;
                    end
                    prev_sym_next = pick;
                    cur_sym_next  = pick;
                    sym           = pick;
                end
                out_next.pulse_valid   = 1'b1;
                out_next.symbol_sent   = sym;
                out_next.pulse_len_us  = BASE_WIDTH_US + STEP_WIDTH_US * {6'd0, sym};
                out_next.pulse_channel = channel_number;
                if (count >= limit)
                begin
                    frames_next = '0;
                    active_next = 1'b0;
                end
                else
                begin
                    frames_next = count[7:0];
                end
            end
            else if (q_cmd.is_flush)
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
            end
            out_next.fifo_empty = (rd_ptr_next == wr_ptr_next);
        end
    end

    // A byte written into an empty FIFO lands where the head is read.
    assign head_bypass = do_write && (wr_ptr_reg == rd_ptr_next);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= q_cmd.data;
        end
        head_reg <= head_bypass ? q_cmd.data : mem[rd_ptr_next];
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            held_reg        <= '0;
            low_pending_reg <= 1'b0;
            active_reg      <= 1'b0;
            frames_reg      <= '0;
            cur_sym_reg     <= SYM_IDLE;
            prev_sym_reg    <= SYM_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            held_reg        <= held_next;
            low_pending_reg <= low_pending_next;
            active_reg      <= active_next;
            frames_reg      <= frames_next;
            cur_sym_reg     <= cur_sym_next;
            prev_sym_reg    <= prev_sym_next;
            out_valid_reg   <= fire || (out_valid_reg && !result_ready);
        end
    end

    // The head register tracks the state of the last executed beat until the next one.
    always_comb
    begin
        result           = out_reg;
        result.head_byte = out_reg.fifo_empty ? 8'd0 : head_reg;
    end

    assign result_valid = out_valid_reg;

endmodule

// File: rtl/rc_pulse_nibble_serial_tx.sv
// Sends bytes over one RC servo channel as pulse widths of 1024 + 56 * symbol microseconds.
// The block takes one beat per cycle on the item channel: a byte write, a frame tick or a
// FIFO flush. An accepted beat is written into the two-entry command queue; the execute
// stage then updates the FIFO pointers, the symbol sequencer and the result register
// together, and the result beat is presented from that register. The sustained rate is
// one item per cycle, set by that execute stage and its registered FIFO head read; a
// stalled result holds the execute stage, and the item channel stalls once the queue
// holds two commands.
// Configuration writes are taken in any cycle and should only be issued while idle.
module rc_pulse_nibble_serial_tx
    import rcpn_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           op,
    input  logic [7:0]           data_byte,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 write_accepted,
    output logic                 pulse_valid,
    output logic [10:0]          pulse_len_us,
    output logic [4:0]           symbol_sent,
    output logic [7:0]           pulse_channel,
    output logic                 fifo_empty,
    output logic [7:0]           head_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [8:0]           cfg_data
);

    logic [8:0] frames_per_symbol_reg;
    logic [7:0] channel_number_reg;
    logic       q_full;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    logic       q_valid;
    cmd_t       q_cmd;
    result_t    result;

    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_per_symbol_reg <= FRAMES_RESET;
            channel_number_reg    <= CHANNEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAMES:  frames_per_symbol_reg <= cfg_data;
                CFG_CHANNEL: channel_number_reg    <= cfg_data[7:0];
                default:     channel_number_reg    <= channel_number_reg;
            endcase
        end
    end

    rcpn_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    rcpn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    rcpn_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .pop               (pop),
        .frames_per_symbol (frames_per_symbol_reg),
        .channel_number    (channel_number_reg),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .result            (result)
    );

    assign write_accepted = result.write_accepted;
    assign pulse_valid    = result.pulse_valid;
    assign pulse_len_us   = result.pulse_len_us;
    assign symbol_sent    = result.symbol_sent;
    assign pulse_channel  = result.pulse_channel;
    assign fifo_empty     = result.fifo_empty;
    assign head_byte      = result.head_byte;

    // A queued command is executed as soon as the result register is free.
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !result_valid |=> result_valid)
        else $error("queued command not executed into a free result register");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fifo_empty |-> head_byte == 8'd0)
        else $error("head byte not cleared on an empty FIFO");

    a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && pulse_valid |-> !write_accepted && symbol_sent <= SYM_IDLE)
        else $error("pulse result carries a write flag or a bad symbol");

endmodule
